>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expr must never hold
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");

// cons must hold in the same cycle as ante
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_NEVER(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/lwkd_pkg.sv
// ---------------------------------------------------------------------------
// lwkd_pkg
// sizes, types and register codes for the longest window k-distinct block
// ---------------------------------------------------------------------------
package lwkd_pkg;

  localparam int MAX_LEN  = 4096;
  localparam int SYM_W    = 8;
  localparam int ALPHABET = 1 << SYM_W;
  localparam int IDX_W    = $clog2(MAX_LEN);
  localparam int LEN_W    = $clog2(MAX_LEN + 1);
  localparam int CNT_W    = LEN_W;
  localparam int DIST_W   = $clog2(ALPHABET + 1);

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTINCT = '0;

  localparam logic [DIST_W-1:0] MAX_DISTINCT_RESET = DIST_W'(2);

  typedef logic [SYM_W-1:0]  sym_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DIST_W-1:0] dist_t;

  // second stage: pending drop of the left byte plus the finished result
  typedef struct packed {
    logic drop;
    sym_t old_sym;
    len_t best;
    logic last;
    logic ovf;
  } stage2_t;

endpackage

>>> rtl/core/lwkd_ram.sv
// ---------------------------------------------------------------------------
// lwkd_ram
// simple dual port ram: one write port, one read port, registered read data
// ---------------------------------------------------------------------------
module lwkd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read during write to the same address returns the old data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/longest_window_k_distinct.sv
// ---------------------------------------------------------------------------
// longest_window_k_distinct
// streaming longest window holding at most max_distinct distinct byte values
// ---------------------------------------------------------------------------
// One byte of the string comes in per item and one result goes out per item,
// carrying the best window length so far in the string. The block takes no
// new item while the last one is in stage 1, since the single read port of the
// 256-entry symbol count memory must give the new byte's count and then the
// count of the byte that leaves at the left edge. A result passes through
// stage 1 and stage 2 into the output register, and the output register lets
// the next item in while a result still waits there. A first flag
// clears the counts at once through per-entry valid bits, so there is no
// clearing pass after reset or between strings. Bytes past 4096 in one string
// are dropped and flag overflow. max_distinct sits at byte address 0 of the
// config port and resets to 2.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module longest_window_k_distinct (
  input  logic                               clk,
  input  logic                               rst_n,
  // input items
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_ch,
  input  logic                               in_is_first,
  input  logic                               in_is_last,
  // results
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [12:0]                        out_best_length,
  output logic                               out_string_done,
  output logic                               out_overflow,
  // config port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lwkd_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [lwkd_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [lwkd_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);

  localparam int IDX_W  = lwkd_pkg::IDX_W;
  localparam int LEN_W  = lwkd_pkg::LEN_W;
  localparam int CNT_W  = lwkd_pkg::CNT_W;
  localparam int DIST_W = lwkd_pkg::DIST_W;

  // config
  lwkd_pkg::dist_t max_distinct_r;
  logic            cfg_wr;
  logic [lwkd_pkg::CFG_IDX_W-1:0] cfg_idx;

  // per-string state
  lwkd_pkg::dist_t distinct_r;
  lwkd_pkg::len_t  left_r;
  lwkd_pkg::len_t  right_r;
  lwkd_pkg::len_t  best_r;
  logic            ovf_r;
  logic [lwkd_pkg::ALPHABET-1:0] vld_r;

  // pipeline
  logic              s1_v_r;
  lwkd_pkg::sym_t    s1_sym_r;
  logic              s1_last_r;
  logic              s2_v_r;
  lwkd_pkg::stage2_t s2_r;
  logic              out_valid_r;
  lwkd_pkg::stage2_t out_r;

  // count memory bypass: the write that landed at the edge of the last read
  logic            fwd_v_r;
  lwkd_pkg::sym_t  fwd_addr_r;
  lwkd_pkg::cnt_t  fwd_data_r;

  // memory ports
  logic            cnt_we, cnt_re;
  lwkd_pkg::sym_t  cnt_waddr, cnt_raddr;
  lwkd_pkg::cnt_t  cnt_wdata, cnt_rdata;
  logic            hist_we, hist_re;
  lwkd_pkg::idx_t  hist_waddr, hist_raddr;
  lwkd_pkg::sym_t  hist_wdata, hist_rdata;

  // control
  logic            in_acc, clr, s2_adv;
  logic            in_range, s1_we, s1_drop, s2_wr, s2_last_one;
  lwkd_pkg::cnt_t  s1_cnt, s2_cnt;
  lwkd_pkg::dist_t distinct_nxt;
  lwkd_pkg::len_t  left_nxt, len_nxt, best_nxt;
  lwkd_pkg::sym_t  s1_old;

  assign in_acc   = in_valid & ~in_stall;
  assign clr      = in_acc & in_is_first;
  assign s2_adv   = s2_v_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_v_r | (s2_v_r & ~s2_adv);

  // ---------------- stage 1: add the new byte ----------------
  always_comb begin
    if (fwd_v_r && fwd_addr_r == s1_sym_r) begin
      s1_cnt = fwd_data_r;
    end else if (vld_r[s1_sym_r]) begin
      s1_cnt = cnt_rdata;
    end else begin
      s1_cnt = '0;
    end
  end

  assign in_range     = (right_r != LEN_W'(lwkd_pkg::MAX_LEN));
  assign s1_we        = s1_v_r & in_range;
  assign distinct_nxt = distinct_r + {{(DIST_W-1){1'b0}}, (s1_cnt == '0)};
  assign s1_drop      = in_range & (distinct_nxt > max_distinct_r) & (left_r <= right_r);
  // left edge on the byte written this very item
  assign s1_old       = (left_r == right_r) ? s1_sym_r : hist_rdata;
  assign left_nxt     = left_r + {{(LEN_W-1){1'b0}}, s1_drop};
  assign len_nxt      = right_r + LEN_W'(1) - left_nxt;

  always_comb begin
    if (in_range && len_nxt > best_r) begin
      best_nxt = len_nxt;
    end else begin
      best_nxt = best_r;
    end
  end

  // ---------------- stage 2: drop the left byte ----------------
  always_comb begin
    if (fwd_v_r && fwd_addr_r == s2_r.old_sym) begin
      s2_cnt = fwd_data_r;
    end else if (vld_r[s2_r.old_sym]) begin
      s2_cnt = cnt_rdata;
    end else begin
      s2_cnt = '0;
    end
  end

  assign s2_wr       = s2_adv & s2_r.drop & (s2_cnt != '0);
  assign s2_last_one = (s2_cnt == CNT_W'(1));

  // ---------------- memories ----------------
  // stage 1 and stage 2 never hold items at once, so ports never collide
  assign cnt_we    = s1_we | s2_wr;
  assign cnt_waddr = s1_v_r ? s1_sym_r : s2_r.old_sym;
  assign cnt_wdata = s1_v_r ? (s1_cnt + CNT_W'(1)) : (s2_cnt - CNT_W'(1));
  assign cnt_re    = in_acc | (s1_v_r & s1_drop);
  assign cnt_raddr = in_acc ? in_ch : s1_old;

  assign hist_we    = s1_we;
  assign hist_waddr = right_r[IDX_W-1:0];
  assign hist_wdata = s1_sym_r;
  assign hist_re    = in_acc;
  assign hist_raddr = in_is_first ? '0 : left_r[IDX_W-1:0];

  lwkd_ram #(
    .WIDTH (CNT_W),
    .DEPTH (lwkd_pkg::ALPHABET)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  lwkd_ram #(
    .WIDTH (lwkd_pkg::SYM_W),
    .DEPTH (lwkd_pkg::MAX_LEN)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .re    (hist_re),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
    end else if (cnt_re) begin
      fwd_v_r <= cnt_we & ~clr;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_re) begin
      fwd_addr_r <= cnt_waddr;
      fwd_data_r <= cnt_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
    end else if (cnt_we) begin
      vld_r[cnt_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      distinct_r <= '0;
      left_r     <= '0;
      right_r    <= '0;
      best_r     <= '0;
      ovf_r      <= 1'b0;
    end else if (s1_v_r) begin
      if (in_range) begin
        distinct_r <= distinct_nxt;
        left_r     <= left_nxt;
        right_r    <= right_r + LEN_W'(1);
        best_r     <= best_nxt;
      end else begin
        ovf_r <= 1'b1;
      end
    end else if (s2_wr && s2_last_one) begin
      distinct_r <= distinct_r - DIST_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
      if (s1_v_r) begin
        s2_v_r <= 1'b1;
      end else if (s2_adv) begin
        s2_v_r <= 1'b0;
      end
      if (s2_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sym_r  <= in_ch;
      s1_last_r <= in_is_last;
    end
    if (s1_v_r) begin
      s2_r.drop    <= s1_drop;
      s2_r.old_sym <= s1_old;
      s2_r.best    <= best_nxt;
      s2_r.last    <= s1_last_r;
      s2_r.ovf     <= ovf_r | ~in_range;
    end
    if (s2_adv) begin
      out_r <= s2_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_best_length = out_r.best;
  assign out_string_done = out_r.last;
  assign out_overflow    = out_r.ovf;

  // ---------------- config port ----------------
  assign cfg_idx = paddr[lwkd_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_distinct_r <= lwkd_pkg::MAX_DISTINCT_RESET;
    end else if (cfg_wr && cfg_idx == lwkd_pkg::REG_MAX_DISTINCT) begin
      max_distinct_r <= pwdata[DIST_W-1:0];
    end
  end

  always_comb begin
    if (cfg_idx == lwkd_pkg::REG_MAX_DISTINCT) begin
      prdata = {{(lwkd_pkg::CFG_DATA_W-DIST_W){1'b0}}, max_distinct_r};
    end else begin
      prdata = '0;
    end
  end

  // ---------------- assertions ----------------
  `ASSERT_NEVER(a_stage_overlap, clk, rst_n, s1_v_r && s2_v_r)
  `ASSERT_NEXT(a_stage1_moves_on, clk, rst_n, s1_v_r, s2_v_r)
  `ASSERT_NEVER(a_left_past_right, clk, rst_n, left_r > right_r)
  `ASSERT_IMPLY(a_drop_has_count, clk, rst_n, s2_adv && s2_r.drop, s2_cnt != '0)

endmodule
